// ===== sv/apr_pkg.sv =====
`default_nettype none

package apr_pkg;

    // Plate counts that the ring supports.
    localparam logic [2:0] PLATES_TRI  = 3'd3;
    localparam logic [2:0] PLATES_QUAD = 3'd4;

    // Angle step between neighboring plates, 65536 counts per turn.
    localparam logic [15:0] STEP_QUAD = 16'd16384;
    localparam logic [15:0] STEP_TRI  = 16'd21845;

    // CORDIC start value, 1/gain in Q1.30, and width of the x and y registers.
    localparam int CS_W = 34;
    localparam logic signed [CS_W-1:0] CORDIC_START = 34'sd652032874;

    localparam int ATAN_LEN = 24;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_ROTATE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SUB_Y,
        ST_OUT
    } apr_state_t;

    // Arctangent step rounded half up to units of 2^-ab turn.
    function automatic logic [31:0] atan_step(input int idx, input int ab);
        logic [32:0] sum;
        int          sh;
        sh  = 32 - ab;
        sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (sh - 1));
        return 32'(sum >> sh);
    endfunction

endpackage

`default_nettype wire

// ===== sv/apr_target_if.sv =====
`default_nettype none

interface apr_target_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] yaw_angle;
    logic [17:0]        radius_main;
    logic [17:0]        radius_alt;
    logic signed [31:0] height_second;
    logic signed [31:0] height_third;
    logic [2:0]         plate_count;

    modport source (
        output valid, center_x, center_y, center_z, yaw_angle, radius_main,
               radius_alt, height_second, height_third, plate_count,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, yaw_angle, radius_main,
               radius_alt, height_second, height_third, plate_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/apr_plate_if.sv =====
`default_nettype none

interface apr_plate_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] plate_x;
    logic signed [31:0] plate_y;
    logic signed [31:0] plate_z;
    logic signed [15:0] plate_angle;
    logic [1:0]         plate_index;
    logic               last;
    logic               bad_count;

    modport source (
        output valid, plate_x, plate_y, plate_z, plate_angle, plate_index,
               last, bad_count,
        input  ready
    );
    modport sink (
        input  valid, plate_x, plate_y, plate_z, plate_angle, plate_index,
               last, bad_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/apr_cordic.sv =====
`default_nettype none

module apr_cordic #(
    parameter int ITERATIONS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [15:0]               angle,
    output logic                                  done,
    output logic signed [apr_pkg::CS_W-1:0]       cos_out,
    output logic signed [apr_pkg::CS_W-1:0]       sin_out
);
    import apr_pkg::*;

    localparam int AW      = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 2;
    localparam int ZW      = ANGLE_BITS + 2;
    localparam int ITER_W  = $clog2(ITERATIONS);
    localparam int UP      = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int DN      = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int RND     = (1 << DN) >> 1;
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int HALF    = 1 << (ANGLE_BITS - 1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERATIONS - 1);

    logic                   busy_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic                   neg_reg;
    logic signed [CS_W-1:0] x_reg;
    logic signed [CS_W-1:0] y_reg;
    logic signed [ZW-1:0]   z_reg;

    logic signed [AW-1:0]   a_w;
    logic signed [AW-1:0]   z_int;
    logic signed [AW-1:0]   z_fold;
    logic                   neg_next;
    logic signed [ZW-1:0]   step;
    logic signed [CS_W-1:0] dx;
    logic signed [CS_W-1:0] dy;
    logic signed [CS_W-1:0] x_next;
    logic signed [CS_W-1:0] y_next;
    logic signed [ZW-1:0]   z_next;

    // Scale the binary angle to the internal unit and fold it into the right half plane.
    always_comb
    begin
        a_w = AW'(angle);
        if (ANGLE_BITS >= 16)
        begin
            z_int = a_w <<< UP;
        end
        else
        begin
            z_int = ((a_w + AW'(32768) + AW'(RND)) >>> DN) - AW'(32768 >> DN);
        end
        neg_next = 1'b0;
        z_fold   = z_int;
        if (z_int > AW'(QUARTER))
        begin
            z_fold   = z_int - AW'(HALF);
            neg_next = 1'b1;
        end
        else if (z_int < AW'(-QUARTER))
        begin
            z_fold   = z_int + AW'(HALF);
            neg_next = 1'b1;
        end
    end

    always_comb
    begin
        step = ZW'(atan_step(int'(iter_reg), ANGLE_BITS));
        dx   = y_reg >>> iter_reg;
        dy   = x_reg >>> iter_reg;
        if (!z_reg[ZW-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - step;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= (iter_reg != ITER_LAST);
            iter_reg <= iter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= CORDIC_START;
            y_reg   <= '0;
            z_reg   <= ZW'(z_fold);
            neg_reg <= neg_next;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done    = busy_reg && (iter_reg == ITER_LAST);
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("rotation restarted while busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg)
        else $error("rotation kept running after its last step");
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && (iter_reg == '0))
        else $error("rotation did not begin at the first step");

endmodule

`default_nettype wire

// ===== sv/armor_plate_pose_ring.sv =====
`default_nettype none
// Per plate: set up the angle, run CORDIC_ITERATIONS rotation steps, form the x and y
// offsets on the shared multiplier with rounding and subtract, then hold the output
// word until the sink is ready. A three- or four-plate word yields that many plate words;
// a word with a bad plate count yields one flagged word.
// Throughput: one input word at a time, set by the single rotation unit and multiplier.
// Reset: rst_n is asynchronous and active low; it returns the sequencer to idle.

module armor_plate_pose_ring #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_BITS        = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    apr_target_if.sink target,
    apr_plate_if.source plate
);
    import apr_pkg::*;

    localparam int PW = 19 + CS_W;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1 << 29);

    apr_state_t state_reg;
    apr_state_t state_next;

    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic signed [31:0] h2_reg;
    logic signed [31:0] h3_reg;
    logic [17:0]        rm_reg;
    logic [17:0]        ra_reg;
    logic               quad_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] pz_reg;
    logic signed [15:0] pa_reg;
    logic [1:0]         idx_reg;
    logic               last_reg;
    logic               bad_reg;
    logic signed [PW-1:0] prod_reg;

    logic                   bad_in;
    logic                   cordic_start;
    logic                   cordic_done;
    logic signed [CS_W-1:0] cos_val;
    logic signed [CS_W-1:0] sin_val;
    logic [17:0]            radius;
    logic signed [CS_W-1:0] trig;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   prod_rnd;
    logic signed [31:0]     offset;

    assign bad_in = (target.plate_count != PLATES_TRI) && (target.plate_count != PLATES_QUAD);

    apr_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (pa_reg),
        .done    (cordic_done),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    // One multiplier serves both axes; the rounding and subtract work on the product held in prod_reg.
    always_comb
    begin
        radius   = (quad_reg && idx_reg[0]) ? ra_reg : rm_reg;
        trig     = (state_reg == ST_MUL_X) ? cos_val : sin_val;
        prod     = PW'(signed'({1'b0, radius})) * PW'(trig);
        prod_rnd = (prod_reg + ROUND_HALF) >>> 30;
        offset   = prod_rnd[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (target.valid)
                begin
                    state_next = bad_in ? ST_OUT : ST_ANGLE;
                end
            end
            ST_ANGLE:  state_next = ST_ROTATE;
            ST_ROTATE:
            begin
                if (cordic_done)
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_SUB_Y;
            ST_SUB_Y:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (plate.ready)
                begin
                    state_next = last_reg ? ST_IDLE : ST_ANGLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        target.ready = (state_reg == ST_IDLE);
        plate.valid  = (state_reg == ST_OUT);
        cordic_start = (state_reg == ST_ANGLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (target.valid)
                begin
                    cx_reg   <= target.center_x;
                    cy_reg   <= target.center_y;
                    cz_reg   <= target.center_z;
                    h2_reg   <= target.height_second;
                    h3_reg   <= target.height_third;
                    rm_reg   <= target.radius_main;
                    ra_reg   <= target.radius_alt;
                    quad_reg <= (target.plate_count == PLATES_QUAD);
                    idx_reg  <= 2'd0;
                    bad_reg  <= bad_in;
                    last_reg <= bad_in;
                    if (bad_in)
                    begin
                        px_reg <= '0;
                        py_reg <= '0;
                        pz_reg <= '0;
                        pa_reg <= '0;
                    end
                    else
                    begin
                        pa_reg <= target.yaw_angle;
                    end
                end
            end
            ST_ANGLE:
            begin
                if (quad_reg)
                begin
                    pz_reg   <= idx_reg[0] ? h2_reg : cz_reg;
                    last_reg <= (idx_reg == 2'd3);
                end
                else
                begin
                    pz_reg   <= (idx_reg == 2'd0) ? cz_reg :
                                (idx_reg == 2'd1) ? h2_reg : h3_reg;
                    last_reg <= (idx_reg == 2'd2);
                end
            end
            ST_MUL_X:
            begin
                prod_reg <= prod;
            end
            ST_MUL_Y:
            begin
                prod_reg <= prod;
                px_reg   <= cx_reg - offset;
            end
            ST_SUB_Y:
            begin
                py_reg <= cy_reg - offset;
            end
            ST_OUT:
            begin
                if (plate.ready && !last_reg)
                begin
                    idx_reg <= idx_reg + 2'd1;
                    pa_reg  <= pa_reg + (quad_reg ? STEP_QUAD : STEP_TRI);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign plate.plate_x     = px_reg;
    assign plate.plate_y     = py_reg;
    assign plate.plate_z     = pz_reg;
    assign plate.plate_angle = pa_reg;
    assign plate.plate_index = idx_reg;
    assign plate.last        = last_reg;
    assign plate.bad_count   = bad_reg;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        plate.valid |-> !target.ready)
        else $error("new target taken while a plate word is pending");
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        plate.valid && plate.bad_count |-> plate.last && (plate.plate_index == 2'd0))
        else $error("bad plate count word is not a single final word");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        plate.valid && !plate.bad_count && !quad_reg |-> (plate.plate_index != 2'd3))
        else $error("three-plate ring produced a fourth plate");
    a_done_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == ST_ROTATE))
        else $error("rotation finished outside the rotate step");

endmodule

`default_nettype wire
